@@ design/gbec_pkg.sv @@
// Package for the bridge check block: default sizes and register indexes.
// No dependencies.
package gbec_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 128;

   localparam int VERTEX_BITS      = 6;
   localparam int COUNT_BITS       = 7;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 7;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VERTEX_COUNT = 2'd0,
      CSR_QUERY_END_A  = 2'd1,
      CSR_QUERY_END_B  = 2'd2
   } csr_index_type;

endpackage

@@ design/gbec_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gbec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/graph_bridge_edge_check_top.sv @@
// Bridge check top level: edge loader, adjacency memories and the walk sequencer.
// Depends on gbec_pkg and gbec_ram.
//
// Each start beat carries one undirected edge and stores it in both adjacency lists
// (one head-memory read per endpoint). The beat marked last then starts the
// depth-first check: every adjacency entry passes the step and fetch states, and one
// that reaches a visited vertex or pushes a vertex then the back or push state; a pop
// passes the step and pop states (a walk root only the step state), a walk starts in
// the scan and push states, and the scan steps over visited vertices, as the entry,
// head, discovery and stack memories have registered reads. busy stays high until
// the answer, which is shown for a single cycle on rsp_strobe/rsp_is_bridge; the
// receiver cannot stall it. Results appear only for the last beat.
module graph_bridge_edge_check_top
   import gbec_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [VERTEX_BITS-1:0]    req_edge_from,
   input  logic [VERTEX_BITS-1:0]    req_edge_to,
   input  logic                      req_last_edge,
   output logic                      rsp_strobe,
   output logic                      rsp_is_bridge,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int SLOTS = 2 * MAX_EDGES;
   localparam int SW    = $clog2(SLOTS);
   localparam int PW    = SW + 1;
   localparam int ENW   = PW + VW;
   localparam logic [PW-1:0] EMPTY = PW'(SLOTS);

   typedef struct packed {
      logic [VW-1:0] vert;
      logic [VW-1:0] parent;
      logic          has_parent;
      logic [PW-1:0] cursor;
      logic [CW-1:0] disc;
      logic [CW-1:0] low;
   } frame_type;

   localparam int FW = $bits(frame_type);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ADD1, ST_ADD2, ST_SCAN, ST_PUSH, ST_STEP,
      ST_FETCH, ST_BACK, ST_POPW, ST_DONE
   } state_type;

   state_type         state_ff;
   logic [COUNT_BITS-1:0]  vcount_ff;
   logic [VERTEX_BITS-1:0] qa_ff, qb_ff;
   logic [VW-1:0]     from_ff, to_ff;
   logic              add_ff, last_ff;
   logic [PW-1:0]     cnt_ff;
   logic [MAX_VERTICES-1:0] hvalid_ff, visited_ff;
   logic [CW-1:0]     v_ff, clk_ff, sp_ff;
   logic [VW-1:0]     pend_ff, pend_par_ff;
   logic              pend_hasp_ff;
   frame_type         top_ff;
   logic              found_ff, rsp_strobe_ff, rsp_bit_ff;

   logic              head_we;
   logic [VW-1:0]     head_wa, head_ra;
   logic [SW-1:0]     head_wd, head_rd;
   logic              ent_we;
   logic [SW-1:0]     ent_wa, ent_ra;
   logic [ENW-1:0]    ent_wd, ent_rd;
   logic              disc_we;
   logic [CW-1:0]     disc_rd;
   logic              stk_we;
   logic [VW-1:0]     stk_wa, stk_ra;
   logic [FW-1:0]     stk_rd;

   logic              accept, in_ok;
   logic [VW-1:0]     in_from, in_to, tgt;
   logic [PW-1:0]     nxt, head_ext;
   logic [CW-1:0]     count;
   logic              skip, can_push;
   frame_type         top_upd, pframe, pop_frame;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign in_from  = VW'(32'(req_edge_from));
   assign in_to    = VW'(32'(req_edge_to));
   assign in_ok    = (32'(req_edge_from) < MAX_VERTICES) && (32'(req_edge_to) < MAX_VERTICES)
                     && (32'(cnt_ff) + 2 <= SLOTS);
   assign count    = (32'(vcount_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_ff);
   assign head_ext = {1'b0, head_rd};
   assign tgt      = ent_rd[VW-1:0];
   assign nxt      = ent_rd[ENW-1:VW];
   assign skip     = (32'(tgt) >= 32'(count)) || (top_ff.has_parent && tgt == top_ff.parent);
   assign can_push = !visited_ff[tgt] && (sp_ff < CW'(MAX_VERTICES));
   assign pframe   = frame_type'(stk_rd);

   always_comb begin
      top_upd        = top_ff;
      top_upd.cursor = nxt;
   end

   always_comb begin
      pop_frame = pframe;
      if (top_ff.low < pframe.low) begin
         pop_frame.low = top_ff.low;
      end
   end

   always_comb begin
      head_we = 1'b0;
      head_wa = from_ff;
      head_wd = SW'(cnt_ff);
      head_ra = pend_ff;
      ent_we  = 1'b0;
      ent_wa  = SW'(cnt_ff);
      ent_wd  = {EMPTY, to_ff};
      ent_ra  = SW'(top_ff.cursor);
      disc_we = 1'b0;
      stk_we  = 1'b0;
      stk_wa  = VW'(sp_ff - CW'(1));
      stk_ra  = VW'(sp_ff - CW'(2));
      unique case (state_ff)
         ST_IDLE: begin
            head_ra = in_from;
         end
         ST_ADD1: begin
            head_ra = to_ff;
            head_we = add_ff;
            ent_we  = add_ff;
            ent_wd  = {(hvalid_ff[from_ff] ? head_ext : EMPTY), to_ff};
         end
         ST_ADD2: begin
            head_we = add_ff;
            head_wa = to_ff;
            head_wd = SW'(cnt_ff + PW'(1));
            ent_we  = add_ff;
            ent_wa  = SW'(cnt_ff + PW'(1));
            if (to_ff == from_ff) begin
               ent_wd = {cnt_ff, from_ff};
            end else begin
               ent_wd = {(hvalid_ff[to_ff] ? head_ext : EMPTY), from_ff};
            end
         end
         ST_SCAN: begin
            head_ra = VW'(v_ff);
         end
         ST_PUSH: begin
            disc_we = 1'b1;
         end
         ST_FETCH: begin
            head_ra = tgt;
            stk_we  = !skip && can_push;
         end
         ST_STEP, ST_BACK, ST_POPW, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vcount_ff     <= COUNT_BITS'(1);
         qa_ff         <= '0;
         qb_ff         <= '0;
         cnt_ff        <= '0;
         hvalid_ff     <= '0;
         visited_ff    <= '0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_bit_ff    <= 1'b0;
         sp_ff         <= '0;
         v_ff          <= '0;
         clk_ff        <= '0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_DONE);
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_VERTEX_COUNT: vcount_ff <= csr_data;
               CSR_QUERY_END_A:  qa_ff <= csr_data[VERTEX_BITS-1:0];
               CSR_QUERY_END_B:  qb_ff <= csr_data[VERTEX_BITS-1:0];
               default: begin
               end
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  from_ff  <= in_from;
                  to_ff    <= in_to;
                  add_ff   <= in_ok;
                  last_ff  <= req_last_edge;
                  state_ff <= ST_ADD1;
               end
            end
            ST_ADD1: begin
               if (add_ff) begin
                  hvalid_ff[from_ff] <= 1'b1;
               end
               state_ff <= ST_ADD2;
            end
            ST_ADD2: begin
               if (add_ff) begin
                  hvalid_ff[to_ff] <= 1'b1;
                  cnt_ff <= cnt_ff + PW'(2);
               end
               v_ff     <= '0;
               sp_ff    <= '0;
               clk_ff   <= '0;
               found_ff <= 1'b0;
               state_ff <= last_ff ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
               if (v_ff >= count) begin
                  state_ff <= ST_DONE;
               end else if (visited_ff[VW'(v_ff)]) begin
                  v_ff <= v_ff + CW'(1);
               end else begin
                  pend_ff      <= VW'(v_ff);
                  pend_par_ff  <= '0;
                  pend_hasp_ff <= 1'b0;
                  state_ff     <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               top_ff.vert       <= pend_ff;
               top_ff.parent     <= pend_par_ff;
               top_ff.has_parent <= pend_hasp_ff;
               top_ff.cursor     <= hvalid_ff[pend_ff] ? head_ext : EMPTY;
               top_ff.disc       <= clk_ff;
               top_ff.low        <= clk_ff;
               visited_ff[pend_ff] <= 1'b1;
               clk_ff   <= clk_ff + CW'(1);
               sp_ff    <= sp_ff + CW'(1);
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               if (32'(top_ff.cursor) < SLOTS) begin
                  state_ff <= ST_FETCH;
               end else if (sp_ff == CW'(1)) begin
                  sp_ff    <= '0;
                  state_ff <= ST_SCAN;
               end else begin
                  sp_ff    <= sp_ff - CW'(1);
                  state_ff <= ST_POPW;
               end
            end
            ST_FETCH: begin
               top_ff.cursor <= nxt;
               if (skip) begin
                  state_ff <= ST_STEP;
               end else if (!visited_ff[tgt]) begin
                  if (can_push) begin
                     pend_ff      <= tgt;
                     pend_par_ff  <= top_ff.vert;
                     pend_hasp_ff <= 1'b1;
                     state_ff     <= ST_PUSH;
                  end else begin
                     state_ff <= ST_STEP;
                  end
               end else begin
                  state_ff <= ST_BACK;
               end
            end
            ST_BACK: begin
               if (disc_rd < top_ff.low) begin
                  top_ff.low <= disc_rd;
               end
               state_ff <= ST_STEP;
            end
            ST_POPW: begin
               top_ff <= pop_frame;
               if (top_ff.low > pframe.disc &&
                   ((32'(pframe.vert) == 32'(qa_ff) && 32'(top_ff.vert) == 32'(qb_ff)) ||
                    (32'(pframe.vert) == 32'(qb_ff) && 32'(top_ff.vert) == 32'(qa_ff)))) begin
                  found_ff <= 1'b1;
               end
               state_ff <= ST_STEP;
            end
            ST_DONE: begin
               rsp_bit_ff    <= found_ff;
               visited_ff    <= '0;
               hvalid_ff     <= '0;
               cnt_ff        <= '0;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_is_bridge = rsp_bit_ff;

   gbec_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(head_ra), .rd_data(head_rd)
   );

   gbec_ram #(.WIDTH(ENW), .DEPTH(SLOTS)) u_entry (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_addr(ent_ra), .rd_data(ent_rd)
   );

   gbec_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_disc (
      .clock(clock), .wr_en(disc_we), .wr_addr(pend_ff), .wr_data(clk_ff),
      .rd_addr(tgt), .rd_data(disc_rd)
   );

   gbec_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(FW'(top_upd)),
      .rd_addr(stk_ra), .rd_data(stk_rd)
   );

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(MAX_VERTICES))
      else $error("walk stack overflow");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat did not raise busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DONE))
      else $error("result without finished walk");

endmodule
